/* sv/nixie_clock_set_and_display_defines.svh */
// assertion macros shared by the nixie clock set and display modules
`ifndef NIXIE_CLOCK_SET_AND_DISPLAY_DEFINES_SVH
`define NIXIE_CLOCK_SET_AND_DISPLAY_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define NXC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define NXC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NXC_ASSERT_SAME(lbl, ante, cons, msg)
`define NXC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/nxc_pkg.sv */
// types, codes and digit/tube tables for the nixie clock set and display block
package nxc_pkg;

  typedef logic [3:0] digit_t;

  localparam digit_t DIG_BLANK = 4'd10;
  localparam digit_t DIG_EIGHT = 4'd8;

  // display screens
  localparam logic [2:0] SCR_AUTO    = 3'd0;
  localparam logic [2:0] SCR_TIME    = 3'd1;
  localparam logic [2:0] SCR_DATE    = 3'd2;
  localparam logic [2:0] SCR_WEEKDAY = 3'd3;
  localparam logic [2:0] SCR_SECONDS = 3'd4;

  // set fields
  localparam logic [2:0] STEP_HOUR    = 3'd0;
  localparam logic [2:0] STEP_MINUTE  = 3'd1;
  localparam logic [2:0] STEP_SECOND  = 3'd2;
  localparam logic [2:0] STEP_YEAR    = 3'd3;
  localparam logic [2:0] STEP_MONTH   = 3'd4;
  localparam logic [2:0] STEP_DAY     = 3'd5;
  localparam logic [2:0] STEP_CONFIRM = 3'd6;

  typedef struct packed {
    logic       key_next;
    logic       key_prev;
    logic       key_field;
    logic       key_mode;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [6:0] now_year;
    logic [2:0] now_weekday;
  } nxc_item_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } nxc_setv_t;

  typedef struct packed {
    digit_t a;
    digit_t b;
    digit_t c;
    digit_t d;
    digit_t e;
    digit_t f;
  } nxc_digits_t;

  // tens digit by reciprocal multiply, exact for v < 1029
  function automatic digit_t hi_dig(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic digit_t lo_dig(input logic [6:0] v);
    logic [6:0] q10;
    logic [6:0] r;
    q10 = {3'd0, hi_dig(v)} * 7'd10;
    r   = v - q10;
    return r[3:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] yr);
    logic       leap;
    logic [4:0] n;
    // years 2000..2127: only 2100 breaks the every-fourth-year rule
    leap = (yr[1:0] == 2'd0) && (yr != 7'd100);
    unique case (m)
      4'd2:                         n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      default:                      n = 5'd31;
    endcase
    if ((m == 4'd2) && leap) n = 5'd29;
    return n;
  endfunction

  function automatic logic [7:0] tab_a0(input digit_t d);
    unique case (d)
      4'd0: return 8'h04;
      4'd1: return 8'h08;
      4'd2: return 8'h10;
      4'd3: return 8'h20;
      4'd4: return 8'h40;
      4'd5: return 8'h80;
      4'd8: return 8'h01;
      4'd9: return 8'h02;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_a1(input digit_t d);
    unique case (d)
      4'd6: return 8'h40;
      4'd7: return 8'h80;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_b0(input digit_t d);
    unique case (d)
      4'd0: return 8'h01;
      4'd1: return 8'h02;
      4'd2: return 8'h04;
      4'd3: return 8'h08;
      4'd4: return 8'h10;
      4'd5: return 8'h20;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_b1(input digit_t d);
    unique case (d)
      4'd6: return 8'h10;
      4'd7: return 8'h20;
      4'd8: return 8'h40;
      4'd9: return 8'h80;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_c0(input digit_t d);
    unique case (d)
      4'd4: return 8'h01;
      4'd5: return 8'h02;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_c1(input digit_t d);
    unique case (d)
      4'd0: return 8'h10;
      4'd1: return 8'h20;
      4'd2: return 8'h40;
      4'd3: return 8'h80;
      4'd6: return 8'h01;
      4'd7: return 8'h02;
      4'd8: return 8'h04;
      4'd9: return 8'h08;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_d0(input digit_t d);
    unique case (d)
      4'd2: return 8'h01;
      4'd3: return 8'h02;
      4'd4: return 8'h04;
      4'd5: return 8'h08;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tab_d1(input digit_t d);
    unique case (d)
      4'd0: return 8'h40;
      4'd1: return 8'h80;
      4'd6: return 8'h04;
      4'd7: return 8'h08;
      4'd8: return 8'h10;
      4'd9: return 8'h20;
      default: return 8'h00;
    endcase
  endfunction

endpackage

/* sv/nxc_ctrl.sv */
// mode, screen and set-value state with per-word digit selection
`include "nixie_clock_set_and_display_defines.svh"

module nxc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  nxc_pkg::nxc_item_t  item,
  output nxc_pkg::nxc_digits_t digits,
  output logic                commit,
  output nxc_pkg::nxc_setv_t  setv
);
  import nxc_pkg::*;

  logic       mode_r, mode_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] scr_r, scr_nxt;
  nxc_setv_t  val_r, val_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      step_r       <= STEP_HOUR;
      scr_r        <= SCR_AUTO;
      val_r.hour   <= 5'd12;
      val_r.minute <= 6'd0;
      val_r.second <= 6'd0;
      val_r.day    <= 5'd1;
      val_r.month  <= 4'd1;
      val_r.year   <= 7'd20;
    end else if (adv) begin
      mode_r <= mode_nxt;
      step_r <= step_nxt;
      scr_r  <= scr_nxt;
      val_r  <= val_nxt;
    end
  end

  always_comb begin
    nxc_digits_t tm, dt;
    digit_t      sd;
    logic [3:0]  wsum, wmod;
    logic [4:0]  len;
    mode_nxt = mode_r;
    step_nxt = step_r;
    scr_nxt  = scr_r;
    val_nxt  = val_r;
    commit   = 1'b0;
    digits   = '{DIG_BLANK, DIG_BLANK, DIG_BLANK, DIG_BLANK, DIG_BLANK, DIG_BLANK};

    sd = lo_dig({1'b0, item.now_second});
    tm = '{hi_dig({2'd0, item.now_hour}), lo_dig({2'd0, item.now_hour}),
           hi_dig({1'b0, item.now_minute}), lo_dig({1'b0, item.now_minute}),
           hi_dig({1'b0, item.now_second}), sd};
    dt = '{hi_dig(item.now_year), lo_dig(item.now_year),
           hi_dig({3'd0, item.now_month}), lo_dig({3'd0, item.now_month}),
           hi_dig({2'd0, item.now_day}), lo_dig({2'd0, item.now_day})};
    // shift clock weekday by five places, mod 7, then back to 1..7
    wsum = {1'b0, item.now_weekday} + 4'd5;
    wmod = (wsum >= 4'd7) ? (wsum - 4'd7) : wsum;
    len  = 5'd31;

    if (item.key_mode) begin
      if (!mode_r) begin
        mode_nxt = 1'b1;
      end else begin
        commit   = (step_r == STEP_CONFIRM);
        mode_nxt = 1'b0;
        step_nxt = STEP_HOUR;
      end
    end

    if (!mode_nxt) begin
      if (item.key_next) scr_nxt = (scr_nxt < SCR_SECONDS) ? scr_nxt + 3'd1 : SCR_AUTO;
      if (item.key_prev) scr_nxt = (scr_nxt > SCR_AUTO) ? scr_nxt - 3'd1 : SCR_WEEKDAY;
      unique case (scr_nxt)
        SCR_AUTO: begin
          if ((item.now_second < 6'd10) && item.now_minute[0]) begin
            digits = '{sd, sd, sd, sd, sd, sd};
          end else if ((item.now_second == 6'd14) || (item.now_second == 6'd15) ||
                       (item.now_second == 6'd44) || (item.now_second == 6'd45)) begin
            digits = dt;
          end else begin
            digits = tm;
          end
        end
        SCR_TIME:    digits = tm;
        SCR_DATE:    digits = dt;
        SCR_WEEKDAY: digits.a = wmod + 4'd1;
        SCR_SECONDS: digits = '{sd, sd, sd, sd, sd, sd};
        default: ;
      endcase
    end else begin
      if (item.key_field) step_nxt = (step_nxt < STEP_CONFIRM) ? step_nxt + 3'd1 : STEP_HOUR;
      unique case (step_nxt)
        STEP_HOUR: begin
          if (item.key_next)
            val_nxt.hour = (val_nxt.hour < 5'd23) ? val_nxt.hour + 5'd1 : 5'd0;
          if (item.key_prev)
            val_nxt.hour = (val_nxt.hour > 5'd0) ? val_nxt.hour - 5'd1 : 5'd23;
          digits.e = hi_dig({2'd0, val_nxt.hour});
          digits.f = lo_dig({2'd0, val_nxt.hour});
        end
        STEP_MINUTE: begin
          if (item.key_next)
            val_nxt.minute = (val_nxt.minute < 6'd59) ? val_nxt.minute + 6'd1 : 6'd0;
          if (item.key_prev)
            val_nxt.minute = (val_nxt.minute > 6'd0) ? val_nxt.minute - 6'd1 : 6'd59;
          digits.c = hi_dig({2'd0, val_nxt.hour});
          digits.d = lo_dig({2'd0, val_nxt.hour});
          digits.e = hi_dig({1'b0, val_nxt.minute});
          digits.f = lo_dig({1'b0, val_nxt.minute});
        end
        STEP_SECOND: begin
          if (item.key_next)
            val_nxt.second = (val_nxt.second < 6'd59) ? val_nxt.second + 6'd1 : 6'd0;
          if (item.key_prev)
            val_nxt.second = (val_nxt.second > 6'd0) ? val_nxt.second - 6'd1 : 6'd59;
          digits = '{hi_dig({2'd0, val_nxt.hour}), lo_dig({2'd0, val_nxt.hour}),
                     hi_dig({1'b0, val_nxt.minute}), lo_dig({1'b0, val_nxt.minute}),
                     hi_dig({1'b0, val_nxt.second}), lo_dig({1'b0, val_nxt.second})};
        end
        STEP_YEAR: begin
          // day is clamped after each change, so next-then-prev can shorten it
          if (item.key_next) begin
            val_nxt.year = (val_nxt.year < 7'd99) ? val_nxt.year + 7'd1 : 7'd0;
            len = month_len(val_nxt.month, val_nxt.year);
            if (val_nxt.day > len) val_nxt.day = len;
          end
          if (item.key_prev) begin
            val_nxt.year = (val_nxt.year > 7'd0) ? val_nxt.year - 7'd1 : 7'd99;
            len = month_len(val_nxt.month, val_nxt.year);
            if (val_nxt.day > len) val_nxt.day = len;
          end
          digits.e = hi_dig(val_nxt.year);
          digits.f = lo_dig(val_nxt.year);
        end
        STEP_MONTH: begin
          if (item.key_next) begin
            val_nxt.month = (val_nxt.month < 4'd12) ? val_nxt.month + 4'd1 : 4'd1;
            len = month_len(val_nxt.month, val_nxt.year);
            if (val_nxt.day > len) val_nxt.day = len;
          end
          if (item.key_prev) begin
            val_nxt.month = (val_nxt.month > 4'd1) ? val_nxt.month - 4'd1 : 4'd12;
            len = month_len(val_nxt.month, val_nxt.year);
            if (val_nxt.day > len) val_nxt.day = len;
          end
          digits.c = hi_dig(val_nxt.year);
          digits.d = lo_dig(val_nxt.year);
          digits.e = hi_dig({3'd0, val_nxt.month});
          digits.f = lo_dig({3'd0, val_nxt.month});
        end
        STEP_DAY: begin
          len = month_len(val_nxt.month, val_nxt.year);
          if (item.key_next)
            val_nxt.day = (val_nxt.day < len) ? val_nxt.day + 5'd1 : 5'd1;
          if (item.key_prev)
            val_nxt.day = (val_nxt.day > 5'd1) ? val_nxt.day - 5'd1 : len;
          digits = '{hi_dig(val_nxt.year), lo_dig(val_nxt.year),
                     hi_dig({3'd0, val_nxt.month}), lo_dig({3'd0, val_nxt.month}),
                     hi_dig({2'd0, val_nxt.day}), lo_dig({2'd0, val_nxt.day})};
        end
        STEP_CONFIRM: digits = '{DIG_EIGHT, DIG_EIGHT, DIG_EIGHT, DIG_EIGHT, DIG_EIGHT, DIG_EIGHT};
        default: ;
      endcase
    end
  end

  assign setv = val_nxt;

  `NXC_ASSERT_SAME(a_step_idle, !mode_r, step_r == STEP_HOUR, "set step moved in display mode")
  `NXC_ASSERT_SAME(a_day_range, 1'b1, (val_r.day >= 5'd1) && (val_r.day <= month_len(val_r.month, val_r.year)), "day outside month")
  `NXC_ASSERT_SAME(a_hms_range, 1'b1, (val_r.hour <= 5'd23) && (val_r.minute <= 6'd59) && (val_r.second <= 6'd59), "time value out of range")
  `NXC_ASSERT_SAME(a_commit_exit, adv && commit, mode_r && !mode_nxt, "commit without leaving set mode")

endmodule

/* sv/nxc_tube.sv */
// maps six tube digits onto the 64 driver shift bits
module nxc_tube (
  input  nxc_pkg::nxc_digits_t digits,
  output logic [63:0]          bits
);
  import nxc_pkg::*;

  assign bits = {tab_a0(digits.a),
                 tab_a1(digits.a) | tab_b0(digits.b),
                 tab_b1(digits.b) | tab_c0(digits.c),
                 tab_c1(digits.c),
                 tab_a0(digits.d),
                 tab_a1(digits.d) | tab_d0(digits.e),
                 tab_d1(digits.e) | tab_c0(digits.f),
                 tab_c1(digits.f)};

endmodule

/* sv/nixie_clock_set_and_display.sv */
// top level of the nixie clock set and display controller
//
// One input word per tick: four button levels and the clock's current time.
// One result word per input word: the 64 tube shift bits (first byte sent in
// bits 63:56), a commit flag and the set values as held after the tick.
// When commit is 1 the set values are to be written into the clock.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The input word is captured in an input register, processed by one
// level of table logic into the result register: out_valid rises once the
// word has moved from the input register into the result register, and one
// word per cycle is sustained while out_stall is low. The result
// register lets a new word be taken while the previous result waits.
// When out_stall holds the result, the input register keeps its word and
// in_stall rises once it is full; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties both registers and returns to display
// mode, auto-rotate screen, set values 12:00:00 on 2020-01-01.
`include "nixie_clock_set_and_display_defines.svh"

module nixie_clock_set_and_display (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_key_next,
  input  logic        in_key_prev,
  input  logic        in_key_field,
  input  logic        in_key_mode,
  input  logic [5:0]  in_now_second,
  input  logic [5:0]  in_now_minute,
  input  logic [4:0]  in_now_hour,
  input  logic [4:0]  in_now_day,
  input  logic [3:0]  in_now_month,
  input  logic [6:0]  in_now_year,
  input  logic [2:0]  in_now_weekday,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_tube_bits,
  output logic        out_commit,
  output logic [4:0]  out_new_hour,
  output logic [5:0]  out_new_minute,
  output logic [5:0]  out_new_second,
  output logic [4:0]  out_new_day,
  output logic [3:0]  out_new_month,
  output logic [6:0]  out_new_year
);
  import nxc_pkg::*;

  logic        s1_valid_r;
  nxc_item_t   s1_item_r;
  logic        out_valid_r;
  logic [63:0] tube_r;
  logic        commit_r;
  nxc_setv_t   setv_r;

  logic        adv;
  logic        in_take;
  nxc_digits_t digits;
  logic        commit;
  nxc_setv_t   setv;
  logic [63:0] bits;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{in_key_next, in_key_prev, in_key_field, in_key_mode,
                     in_now_second, in_now_minute, in_now_hour, in_now_day,
                     in_now_month, in_now_year, in_now_weekday};
    end
  end

  nxc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (s1_item_r),
    .digits (digits),
    .commit (commit),
    .setv   (setv)
  );

  nxc_tube u_tube (
    .digits (digits),
    .bits   (bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tube_r   <= bits;
      commit_r <= commit;
      setv_r   <= setv;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tube_bits  = tube_r;
  assign out_commit     = commit_r;
  assign out_new_hour   = setv_r.hour;
  assign out_new_minute = setv_r.minute;
  assign out_new_second = setv_r.second;
  assign out_new_day    = setv_r.day;
  assign out_new_month  = setv_r.month;
  assign out_new_year   = setv_r.year;

  `NXC_ASSERT_NEXT(a_word_kept, s1_valid_r && out_valid_r && out_stall, s1_valid_r, "held input word lost")
  `NXC_ASSERT_NEXT(a_result_shown, adv, out_valid_r, "processed word produced no result")
  `NXC_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r, "stalled result dropped")

endmodule
